// ----- sv/spq_pkg.sv -----
// shuffle play queue package: opcodes, repeat codes and generator constants
// no dependencies; imported by spq_mod, the queue unit and the testbench
`timescale 1ns / 1ps

package spq_pkg;

    // event opcodes
    localparam logic [2:0] OP_LOAD     = 3'd0;
    localparam logic [2:0] OP_START_AT = 3'd1;
    localparam logic [2:0] OP_END      = 3'd2;
    localparam logic [2:0] OP_SKIP     = 3'd3;
    localparam logic [2:0] OP_SHUFFLE  = 3'd4;

    // repeat modes
    localparam logic [1:0] REP_OFF = 2'd0;
    localparam logic [1:0] REP_ONE = 2'd1;
    localparam logic [1:0] REP_ALL = 2'd2;
    localparam logic [1:0] REP_BAD = 2'd3;

    // xorshift generator
    localparam int          RNG_W    = 32;
    localparam int          RNG_SH_A = 13;
    localparam int          RNG_SH_B = 17;
    localparam int          RNG_SH_C = 5;
    localparam logic [31:0] RNG_SEED = 32'd1;

    typedef logic [RNG_W-1:0] t_rng;

    // one xorshift step
    function automatic t_rng rng_next(input t_rng x);
        t_rng a;
        t_rng b;
        a = x ^ (x << RNG_SH_A);
        b = a ^ (a >> RNG_SH_B);
        return b ^ (b << RNG_SH_C);
    endfunction

endpackage

// ----- sv/spq_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- sv/spq_mod.sv -----
// bit-serial remainder unit: 32-bit dividend modulo a narrow divisor
// depends on spq_pkg for the generator word width
`timescale 1ns / 1ps

module spq_mod #(
    parameter int DW = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  spq_pkg::t_rng       i_dividend,
    input  logic [DW-1:0]       i_divisor,
    output logic                o_done,
    output logic [DW-1:0]       o_rem
);
    import spq_pkg::*;

    localparam int NW = $clog2(RNG_W);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [NW-1:0] r_cnt, n_cnt;
    t_rng          r_x, n_x;
    logic [DW-1:0] r_d, n_d;
    logic [DW:0]   r_rem, n_rem;
    logic [DW:0]   trial;

    // one restoring step per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_d    = r_d;
        n_rem  = r_rem;
        trial  = {r_rem[DW-1:0], r_x[RNG_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = NW'(RNG_W - 1);
            n_x    = i_dividend;
            n_d    = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_x = r_x << 1;
            if (trial >= {1'b0, r_d}) begin
                n_rem = trial - {1'b0, r_d};
            end else begin
                n_rem = trial;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_x   <= n_x;
        r_d   <= n_d;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[DW-1:0];

endmodule

// ----- sv/shuffle_play_queue_unit.sv -----
// Shuffle play queue: the play order lives in one ram of MAX_TRACKS entries
// with a registered read; every event ends with a read of the entry under
// the cursor and a one-cycle o_done strobe carrying o_track and o_position,
// which the receiver must take in that cycle. o_busy is high from the
// accepted start until the strobe cycle. Load runs an identity sweep over
// the count entries; every reshuffle draws a bit-serial remainder from the
// modulo unit for each swapped entry, then swaps the two entries in the ram.
// Start-at searches the ram one entry at a time. repeat_mode may be written
// only while o_busy is low.
// depends on spq_pkg, spq_ram and spq_mod
`timescale 1ns / 1ps

module shuffle_play_queue_unit #(
    parameter int MAX_TRACKS = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [1:0]                            i_cfg_wr_data,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [2:0]                            i_opcode,
    input  logic [$clog2(MAX_TRACKS+1)-1:0]       i_track_count,
    input  logic [$clog2(MAX_TRACKS)-1:0]         i_library_index,
    input  logic signed [$clog2(MAX_TRACKS+1):0]  i_step,
    input  logic                                  i_shuffle_on,
    output logic                                  o_done,
    output logic signed [$clog2(MAX_TRACKS):0]    o_track,
    output logic [$clog2(MAX_TRACKS+1)-1:0]       o_position
);
    import spq_pkg::*;

    localparam int AW = $clog2(MAX_TRACKS);
    localparam int CW = $clog2(MAX_TRACKS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_IDENT, S_SH_CHK, S_SH_DRAW, S_SH_MOD, S_SH_RDH, S_SH_RDJ,
        S_SH_WRH, S_SH_WRJ, S_FIND_RD, S_FIND_CMP, S_FRONT_RD, S_FRONT_WR0,
        S_FRONT_WRP, S_NOW_RD, S_NOW_CHK, S_RES_RD, S_RES_OUT
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_cursor, n_cursor;
    logic            r_flag, n_flag;
    t_rng            r_rng, n_rng;
    logic [1:0]      r_rep, n_rep;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_start, n_start;
    logic [AW-1:0]   r_j, n_j;
    logic [AW-1:0]   r_dhi, n_dhi;
    logic [AW-1:0]   r_lib, n_lib;
    logic            r_on, n_on;
    logic            r_then_shuf, n_then_shuf;
    logic            r_done, n_done;
    logic [AW:0]     r_track, n_track;
    logic [CW-1:0]   r_pos, n_pos;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_wdata, ram_raddr, ram_rdata;
    logic            mod_start, mod_done;
    logic [CW-1:0]   mod_rem;
    t_rng            rng_draw;
    logic [CW-1:0]   hi, span, cur_c;
    logic [1:0]      rep;
    logic            cur_valid;
    logic signed [CW+1:0] pos;

    spq_ram #(.WIDTH(AW), .DEPTH(MAX_TRACKS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    spq_mod #(.DW(CW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (rng_draw),
        .i_divisor  (span),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // shared decode
    assign rng_draw  = rng_next(r_rng);
    assign hi        = r_idx - 1'b1;
    assign span      = r_idx - r_start;
    assign rep       = (r_rep == REP_BAD) ? REP_OFF : r_rep;
    assign cur_valid = (r_count != '0) && (r_cursor < r_count);
    assign cur_c     = (r_cursor >= r_count) ? r_count - 1'b1 : r_cursor;
    assign pos       = $signed({2'b00, cur_c}) + {i_step[CW], i_step};
    assign o_busy    = (r_state != S_IDLE);

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = r_cursor[AW-1:0];
        unique case (r_state)
            S_IDENT: begin
                ram_we    = (r_idx < r_count);
                ram_waddr = r_idx[AW-1:0];
                ram_wdata = r_idx[AW-1:0];
            end
            S_SH_RDH:    ram_raddr = hi[AW-1:0];
            S_SH_RDJ:    ram_raddr = r_j;
            S_SH_WRH: begin
                ram_we    = 1'b1;
                ram_waddr = hi[AW-1:0];
                ram_wdata = ram_rdata;
            end
            S_SH_WRJ: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_dhi;
            end
            S_FIND_RD:   ram_raddr = r_idx[AW-1:0];
            S_FRONT_RD:  ram_raddr = '0;
            S_FRONT_WR0: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_lib;
            end
            S_FRONT_WRP: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                ram_wdata = r_dhi;
            end
            default: ;
        endcase
    end

    // event sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_flag      = r_flag;
        n_rng       = r_rng;
        n_rep       = i_cfg_wr_en ? i_cfg_wr_data : r_rep;
        n_idx       = r_idx;
        n_start     = r_start;
        n_j         = r_j;
        n_dhi       = r_dhi;
        n_lib       = r_lib;
        n_on        = r_on;
        n_then_shuf = r_then_shuf;
        n_done      = 1'b0;
        n_track     = r_track;
        n_pos       = r_pos;
        mod_start   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RES_RD;
                    case (i_opcode)
                        OP_LOAD: begin
                            n_count     = (i_track_count > CW'(MAX_TRACKS)) ?
                                          CW'(MAX_TRACKS) : i_track_count;
                            n_cursor    = '0;
                            n_idx       = '0;
                            n_then_shuf = r_flag;
                            n_start     = '0;
                            n_state     = S_IDENT;
                        end
                        OP_START_AT: begin
                            if (r_count != '0 && {1'b0, i_library_index} < r_count) begin
                                n_lib   = i_library_index;
                                n_idx   = '0;
                                n_state = S_FIND_RD;
                            end
                        end
                        OP_END: begin
                            if (r_count != '0 && rep != REP_ONE) begin
                                if (r_cursor + 1'b1 < r_count) begin
                                    n_cursor = r_cursor + 1'b1;
                                end else if (rep == REP_ALL) begin
                                    n_cursor = '0;
                                    if (r_flag) begin
                                        n_start = '0;
                                        n_idx   = r_count;
                                        n_state = S_SH_CHK;
                                    end
                                end else begin
                                    n_cursor = r_count;
                                end
                            end
                        end
                        OP_SKIP: begin
                            if (r_count != '0) begin
                                if (pos < 0) begin
                                    n_cursor = (rep == REP_OFF) ? '0 : r_count - 1'b1;
                                end else if (pos >= $signed({2'b00, r_count})) begin
                                    if (rep == REP_OFF) begin
                                        n_cursor = r_count;
                                    end else begin
                                        n_cursor = '0;
                                        if (r_flag) begin
                                            n_start = '0;
                                            n_idx   = r_count;
                                            n_state = S_SH_CHK;
                                        end
                                    end
                                end else begin
                                    n_cursor = pos[CW-1:0];
                                end
                            end
                        end
                        OP_SHUFFLE: begin
                            if (i_shuffle_on != r_flag) begin
                                n_flag = i_shuffle_on;
                                n_on   = i_shuffle_on;
                                if (r_count != '0) begin
                                    n_state = S_NOW_RD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // identity sweep, one entry a cycle
            S_IDENT: begin
                if (r_idx < r_count) begin
                    n_idx = r_idx + 1'b1;
                end else if (r_then_shuf) begin
                    n_idx   = r_count;
                    n_state = S_SH_CHK;
                end else begin
                    n_state = S_RES_RD;
                end
            end
            // fisher-yates tail: r_idx is one past the entry being placed
            S_SH_CHK: begin
                if ({1'b0, r_idx} > {1'b0, r_start} + 1'b1) begin
                    n_state = S_SH_DRAW;
                end else begin
                    n_state = S_RES_RD;
                end
            end
            S_SH_DRAW: begin
                n_rng     = rng_draw;
                mod_start = 1'b1;
                n_state   = S_SH_MOD;
            end
            S_SH_MOD: begin
                if (mod_done) begin
                    n_j     = AW'(r_start + mod_rem);
                    n_state = S_SH_RDH;
                end
            end
            S_SH_RDH: n_state = S_SH_RDJ;
            S_SH_RDJ: begin
                n_dhi   = ram_rdata;
                n_state = S_SH_WRH;
            end
            S_SH_WRH: n_state = S_SH_WRJ;
            S_SH_WRJ: begin
                n_idx   = hi;
                n_state = S_SH_CHK;
            end
            // search the order for the requested track
            S_FIND_RD: n_state = S_FIND_CMP;
            S_FIND_CMP: begin
                if (ram_rdata == r_lib) begin
                    if (!r_flag) begin
                        n_cursor = r_idx;
                        n_state  = S_RES_RD;
                    end else begin
                        n_state = S_FRONT_RD;
                    end
                end else if (r_idx + 1'b1 < r_count) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_FIND_RD;
                end else begin
                    n_state = S_RES_RD;
                end
            end
            // swap the found track to the front
            S_FRONT_RD: n_state = S_FRONT_WR0;
            S_FRONT_WR0: begin
                n_dhi   = ram_rdata;
                n_state = S_FRONT_WRP;
            end
            S_FRONT_WRP: begin
                n_cursor = '0;
                n_start  = CW'(1);
                n_idx    = r_count;
                n_state  = S_SH_CHK;
            end
            // shuffle toggle needs the track under the cursor
            S_NOW_RD: n_state = S_NOW_CHK;
            S_NOW_CHK: begin
                if (r_on) begin
                    n_start = cur_valid ? r_cursor + 1'b1 : '0;
                    n_idx   = r_count;
                    n_state = S_SH_CHK;
                end else begin
                    n_cursor    = cur_valid ? CW'(ram_rdata) : '0;
                    n_idx       = '0;
                    n_then_shuf = 1'b0;
                    n_state     = S_IDENT;
                end
            end
            // report the current track
            S_RES_RD: n_state = S_RES_OUT;
            S_RES_OUT: begin
                n_track = cur_valid ? {1'b0, ram_rdata} : '1;
                n_pos   = r_cursor;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_flag   <= 1'b0;
            r_rng    <= RNG_SEED;
            r_rep    <= REP_OFF;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_flag   <= n_flag;
            r_rng    <= n_rng;
            r_rep    <= n_rep;
            r_done   <= n_done;
        end
        r_idx       <= n_idx;
        r_start     <= n_start;
        r_j         <= n_j;
        r_dhi       <= n_dhi;
        r_lib       <= n_lib;
        r_on        <= n_on;
        r_then_shuf <= n_then_shuf;
        r_track     <= n_track;
        r_pos       <= n_pos;
    end

    assign o_done     = r_done;
    assign o_track    = $signed(r_track);
    assign o_position = r_pos;

endmodule

// ----- tb/tb_top.sv -----
// testbench for shuffle_play_queue_unit: queue-fed driver, strobe monitor and
// a behavioral play-queue predictor checked field by field on every result
// depends on spq_pkg and the shuffle_play_queue_unit rtl
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam int  NTRK  = 256;
    localparam longint LIMIT = 10000000;

    typedef struct packed {
        logic [2:0]        op;
        logic [8:0]        tc;
        logic [7:0]        lib;
        logic signed [9:0] step;
        logic              on;
    } t_event;

    typedef struct packed {
        logic [8:0] trk;
        logic [8:0] pos;
    } t_play;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [1:0]        i_cfg_wr_data = REP_OFF;
    logic              i_start = 1'b0;
    logic [2:0]        i_opcode = OP_LOAD;
    logic [8:0]        i_track_count = '0;
    logic [7:0]        i_library_index = '0;
    logic signed [9:0] i_step = '0;
    logic              i_shuffle_on = 1'b0;
    logic              o_busy;
    logic              o_done;
    logic signed [8:0] o_track;
    logic [8:0]        o_position;

    shuffle_play_queue_unit #(.MAX_TRACKS(NTRK)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_start(i_start), .o_busy(o_busy),
        .i_opcode(i_opcode), .i_track_count(i_track_count),
        .i_library_index(i_library_index), .i_step(i_step),
        .i_shuffle_on(i_shuffle_on),
        .o_done(o_done), .o_track(o_track), .o_position(o_position)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_event pending_events[$];
    t_play  expected_plays[$];
    int     idle_pct = 20;
    int     errors = 0;
    longint cycles = 0;

    // queue model state
    logic [7:0]  m_order[NTRK];
    int          m_cursor;
    int          m_count;
    bit          m_shuffle;
    logic [31:0] m_rng;
    logic [1:0]  m_repeat;

    function automatic logic [31:0] next_draw();
        m_rng = m_rng ^ (m_rng << 13);
        m_rng = m_rng ^ (m_rng >> 17);
        m_rng = m_rng ^ (m_rng << 5);
        return m_rng;
    endfunction

    // fisher-yates pass over the order from position lo to the end
    function automatic void shuffle_from(int lo);
        int          hi;
        logic [31:0] span;
        int          j;
        logic [7:0]  t;
        for (int i = m_count; i > lo + 1; i--) begin
            hi = i - 1;
            span = hi - lo + 1;
            j = lo + int'(next_draw() % span);
            t = m_order[hi];
            m_order[hi] = m_order[j];
            m_order[j] = t;
        end
    endfunction

    function automatic void library_order();
        for (int i = 0; i < m_count; i++) m_order[i] = i[7:0];
    endfunction

    function automatic int playing_track();
        if (m_count == 0 || m_cursor >= m_count) return -1;
        return int'(m_order[m_cursor]);
    endfunction

    // apply one event to the queue model and return the reported play state
    function automatic t_play apply_event(t_event ev);
        int         rp;
        int         p;
        int         target;
        int         playing;
        logic [7:0] t;
        t_play      res;
        rp = (m_repeat == REP_BAD) ? int'(REP_OFF) : int'(m_repeat);
        case (ev.op)
            OP_LOAD: begin
                m_count = (ev.tc > NTRK) ? NTRK : int'(ev.tc);
                m_cursor = 0;
                library_order();
                if (m_shuffle) shuffle_from(0);
            end
            OP_START_AT: begin
                if (m_count != 0 && int'(ev.lib) < m_count) begin
                    p = 0;
                    while (p < m_count && m_order[p] != ev.lib) p++;
                    if (p < m_count) begin
                        if (!m_shuffle) begin
                            m_cursor = p;
                        end else begin
                            t = m_order[0];
                            m_order[0] = m_order[p];
                            m_order[p] = t;
                            m_cursor = 0;
                            shuffle_from(1);
                        end
                    end
                end
            end
            OP_END: begin
                if (m_count != 0 && rp != REP_ONE) begin
                    if (m_cursor + 1 < m_count) begin
                        m_cursor++;
                    end else if (rp == REP_ALL) begin
                        if (m_shuffle) shuffle_from(0);
                        m_cursor = 0;
                    end else begin
                        m_cursor = m_count;
                    end
                end
            end
            OP_SKIP: begin
                if (m_count != 0) begin
                    if (m_cursor >= m_count) m_cursor = m_count - 1;
                    target = m_cursor + int'(ev.step);
                    if (target < 0) begin
                        m_cursor = (rp == REP_OFF) ? 0 : m_count - 1;
                    end else if (target >= m_count) begin
                        if (rp == REP_OFF) begin
                            m_cursor = m_count;
                        end else begin
                            if (m_shuffle) shuffle_from(0);
                            m_cursor = 0;
                        end
                    end else begin
                        m_cursor = target;
                    end
                end
            end
            OP_SHUFFLE: begin
                if (ev.on != m_shuffle) begin
                    m_shuffle = ev.on;
                    if (m_count != 0) begin
                        playing = playing_track();
                        if (ev.on) begin
                            shuffle_from(playing >= 0 ? m_cursor + 1 : 0);
                        end else begin
                            library_order();
                            m_cursor = playing >= 0 ? playing : 0;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.trk = 9'(playing_track());
        res.pos = 9'(m_cursor);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [8:0] got,
                                   input logic [8:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, $signed(got), $signed(want), cycles);
        errors++;
    endtask

    // driver: one transaction per accepted start
    t_event cur_ev;
    always @(posedge i_clk) begin
        bit took;
        took = 1'b0;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                expected_plays.push_back(apply_event(cur_ev));
                took = 1'b1;
            end
            if (!i_start || took) begin
                if (pending_events.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_ev = pending_events.pop_front();
                    i_opcode        <= cur_ev.op;
                    i_track_count   <= cur_ev.tc;
                    i_library_index <= cur_ev.lib;
                    i_step          <= cur_ev.step;
                    i_shuffle_on    <= cur_ev.on;
                    i_start         <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_play want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (expected_plays.size() == 0) begin
                $display("unexpected result track %0d position %0d", o_track, o_position);
                errors++;
            end else begin
                want = expected_plays.pop_front();
                if (o_track !== want.trk) report_mismatch("track", o_track, want.trk);
                if (o_position !== want.pos) report_mismatch("position", o_position, want.pos);
            end
        end
    end

    int gen_count = 0;

    function automatic t_event mk(logic [2:0] op, int tc, int lib, int step, bit on);
        t_event ev;
        ev.op = op;
        ev.tc = 9'(tc);
        ev.lib = 8'(lib);
        ev.step = 10'(step);
        ev.on = on;
        return ev;
    endfunction

    // mostly legal play sessions over small libraries, some noise
    function automatic t_event random_event();
        int     r;
        int     tc;
        t_event ev;
        r = $urandom_range(99);
        ev = mk(OP_LOAD, 0, $urandom_range(255), 0, $urandom_range(1));
        ev.step = 10'($urandom_range(10)) - 10'sd5;
        if (r < 12) begin
            r = $urandom_range(99);
            if (r < 6) tc = 0;
            else if (r < 11) tc = $urandom_range(256, 200);
            else tc = $urandom_range(16, 1);
            ev.tc = 9'(tc);
            gen_count = tc;
        end else if (r < 32) begin
            ev.op = OP_START_AT;
            if ($urandom_range(9) != 0) ev.lib = 8'($urandom_range(gen_count + 1));
        end else if (r < 57) begin
            ev.op = OP_END;
        end else if (r < 82) begin
            ev.op = OP_SKIP;
            if ($urandom_range(9) == 0) ev.step = 10'($urandom_range(512)) - 10'sd256;
        end else if (r < 95) begin
            ev.op = OP_SHUFFLE;
        end else begin
            ev.op = 3'($urandom_range(7, 5));
        end
        return ev;
    endfunction

    task automatic wait_drained();
        while (pending_events.size() > 0 || i_start || expected_plays.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_repeat(input logic [1:0] mode);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        m_repeat = mode;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int n, input int idle);
        idle_pct = idle;
        for (int k = 0; k < n; k++) pending_events.push_back(random_event());
    endtask

    // sequence: reset, directed events, then random phases per repeat mode
    initial begin
        m_cursor = 0;
        m_count = 0;
        m_shuffle = 1'b0;
        m_rng = RNG_SEED;
        m_repeat = REP_OFF;
        for (int i = 0; i < NTRK; i++) m_order[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_repeat(REP_OFF);

        // empty queue, extremes, unknown opcodes, shuffle edge cases
        pending_events.push_back(mk(OP_START_AT, 0, 0, 0, 0));
        pending_events.push_back(mk(OP_END, 0, 0, 0, 0));
        pending_events.push_back(mk(OP_SKIP, 0, 0, 1, 0));
        pending_events.push_back(mk(OP_LOAD, 300, 255, -256, 1));
        pending_events.push_back(mk(OP_START_AT, 511, 255, 255, 0));
        pending_events.push_back(mk(OP_SKIP, 0, 0, 256, 0));
        pending_events.push_back(mk(OP_SKIP, 0, 0, -1, 0));
        pending_events.push_back(mk(OP_SKIP, 0, 0, -256, 0));
        pending_events.push_back(mk(OP_START_AT, 0, 0, 0, 0));
        pending_events.push_back(mk(3'd5, 0, 0, 0, 0));
        pending_events.push_back(mk(3'd6, 0, 0, 0, 1));
        pending_events.push_back(mk(3'd7, 0, 0, 0, 0));
        pending_events.push_back(mk(OP_SHUFFLE, 0, 0, 0, 0));
        pending_events.push_back(mk(OP_LOAD, 5, 0, 0, 0));
        pending_events.push_back(mk(OP_SHUFFLE, 0, 0, 0, 1));
        pending_events.push_back(mk(OP_SHUFFLE, 0, 0, 0, 1));
        pending_events.push_back(mk(OP_START_AT, 0, 3, 0, 0));
        pending_events.push_back(mk(OP_START_AT, 0, 9, 0, 0));
        pending_events.push_back(mk(OP_END, 0, 0, 0, 0));
        pending_events.push_back(mk(OP_SKIP, 0, 0, 9, 0));
        pending_events.push_back(mk(OP_END, 0, 0, 0, 0));
        pending_events.push_back(mk(OP_SKIP, 0, 0, -2, 0));
        pending_events.push_back(mk(OP_SHUFFLE, 0, 0, 0, 0));
        pending_events.push_back(mk(OP_LOAD, 0, 0, 0, 0));
        gen_count = 0;

        write_repeat(REP_ALL);
        random_phase(20, 20);
        write_repeat(REP_ONE);
        random_phase(15, 55);
        write_repeat(REP_BAD);
        random_phase(15, 0);
        write_repeat(REP_ALL);
        random_phase(15, 0);
        write_repeat(REP_OFF);
        random_phase(15, 0);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
